// ----- src/mlpf_pkg.sv -----
// Shared codes for the multilevel priority FIFO.
// Operation and status encodings; no dependencies.
package mlpf_pkg;

  // Operation carried in a request beat
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } mlpf_status_t;

endpackage

// ----- src/multilevel_priority_fifo.sv -----
// Multilevel priority FIFO: one bounded FIFO per priority level.
// Uses mlpf_pkg for operation and status codes.
//
// A user's view: each request beat is either an enqueue (in_func = FUNC_ENQ),
// which appends in_value to the FIFO of level in_level, or a dequeue
// (FUNC_DEQ), which removes the oldest word of the highest-numbered level
// that holds anything. Every request beat gives exactly one result beat.
// An enqueue to a full level, or to a level number at or above NUM_LEVELS,
// is dropped and answered with ST_FULL; a dequeue with every level empty is
// answered with ST_EMPTY. out_value and out_level are zero unless a word
// was dequeued. All words live in one single-port-write, registered-read
// memory of NUM_LEVELS * LEVEL_DEPTH entries (level-major, each level a
// ring); the per-level head pointer and fill count sit in flip-flops and
// are cleared by reset, so the memory itself needs no clearing pass.
// Timing: the result of an enqueue or an empty dequeue is registered at
// the edge that accepts it. A dequeue that finds a word goes through the
// registered read port of the word memory, and the request is stalled
// while the read data is moved into the output register. With the result
// side never stalling, the block sustains one enqueue per cycle; after a
// dequeue that finds a word, the next request waits until its data lands.
// in_stall is also high while a result is held and out_stall is high.
module multilevel_priority_fifo #(
  parameter int NUM_LEVELS  = 5,
  parameter int LEVEL_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic [2:0]               in_level,
  input  logic signed [31:0]       in_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output mlpf_pkg::mlpf_status_t   out_status,
  output logic signed [31:0]       out_value,
  output logic [2:0]               out_level
);
  import mlpf_pkg::*;

  localparam int MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PTR_W     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];        // word store, undefined at reset
  logic [DATA_WIDTH-1:0] rd_data_r;              // registered read port

  logic [PTR_W-1:0]      head_r [NUM_LEVELS];
  logic [CNT_W-1:0]      cnt_r  [NUM_LEVELS];

  logic                  pend_r;                 // dequeue read in flight
  logic [LVL_W-1:0]      pend_lvl_r;

  logic                  out_valid_r;
  mlpf_status_t          out_status_r;
  logic [31:0]           out_value_r;
  logic [2:0]            out_level_r;

  // ---------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------
  logic                  in_fire;
  logic                  is_enq;
  logic                  is_deq;
  logic                  lvl_ok;
  logic [LVL_W-1:0]      enq_lvl;
  logic                  enq_full;
  logic                  enq_go;
  logic [CNT_W:0]        slot_sum;
  logic [PTR_W-1:0]      slot;
  logic [ADDR_W-1:0]     wr_addr;

  logic                  any_nonempty;
  logic [LVL_W-1:0]      deq_lvl;
  logic                  deq_go;
  logic [PTR_W:0]        head_inc;
  logic [PTR_W-1:0]      head_nxt;
  logic [ADDR_W-1:0]     rd_addr;

  // Only take a beat when the output register is free (or emptying now)
  // and no dequeue read is waiting to land in it.
  assign in_stall = pend_r | (out_valid_r & out_stall);
  assign in_fire  = in_valid & ~in_stall;
  assign is_enq   = in_func == FUNC_ENQ;
  assign is_deq   = in_func == FUNC_DEQ;

  assign lvl_ok   = 32'(in_level) < 32'(NUM_LEVELS);
  assign enq_lvl  = LVL_W'(in_level);
  assign enq_full = ~lvl_ok || (cnt_r[enq_lvl] >= CNT_W'(LEVEL_DEPTH));
  assign enq_go   = in_fire & is_enq & ~enq_full;

  // Tail slot = (head + count) mod depth; the sum stays below twice depth.
  always_comb begin
    slot_sum = (CNT_W+1)'(head_r[enq_lvl]) + (CNT_W+1)'(cnt_r[enq_lvl]);
    if (slot_sum >= (CNT_W+1)'(LEVEL_DEPTH)) begin
      slot_sum = slot_sum - (CNT_W+1)'(LEVEL_DEPTH);
    end
    slot = PTR_W'(slot_sum);
  end

  assign wr_addr = ADDR_W'(ADDR_W'(enq_lvl) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(slot);

  // Priority pick: highest-numbered non-empty level wins.
  always_comb begin
    any_nonempty = 1'b0;
    deq_lvl      = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (cnt_r[l] != '0) begin
        any_nonempty = 1'b1;
        deq_lvl      = LVL_W'(l);
      end
    end
  end

  assign deq_go   = in_fire & is_deq & any_nonempty;
  assign head_inc = (PTR_W+1)'(head_r[deq_lvl]) + (PTR_W+1)'(1);
  assign head_nxt = (head_inc >= (PTR_W+1)'(LEVEL_DEPTH)) ? '0 : PTR_W'(head_inc);
  assign rd_addr  = ADDR_W'(ADDR_W'(deq_lvl) * ADDR_W'(LEVEL_DEPTH))
                  + ADDR_W'(head_r[deq_lvl]);

  // ---------------------------------------------------------------------
  // Word memory: one write and one registered read per cycle.
  // A write and a read of the same entry never share a cycle (one op a beat).
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (enq_go) begin
      mem[wr_addr] <= DATA_WIDTH'($unsigned(in_value));
    end
    if (deq_go) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Per-level pointers and counts
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else if (enq_go) begin
      cnt_r[enq_lvl] <= cnt_r[enq_lvl] + CNT_W'(1);
    end else if (deq_go) begin
      cnt_r[deq_lvl]  <= cnt_r[deq_lvl] - CNT_W'(1);
      head_r[deq_lvl] <= head_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= deq_go;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (in_fire && !deq_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (deq_go) begin
      pend_lvl_r <= deq_lvl;
    end
    if (pend_r) begin
      out_status_r <= ST_OK;
      out_value_r  <= 32'($unsigned(rd_data_r));
      out_level_r  <= 3'(pend_lvl_r);
    end else if (in_fire && !deq_go) begin
      if (is_enq) begin
        out_status_r <= enq_full ? ST_FULL : ST_OK;
      end else begin
        out_status_r <= ST_EMPTY;
      end
      out_value_r <= '0;
      out_level_r <= '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = signed'(out_value_r);
  assign out_level  = out_level_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  logic cnt_ovf;
  always_comb begin
    cnt_ovf = 1'b0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (cnt_r[l] > CNT_W'(LEVEL_DEPTH)) begin
        cnt_ovf = 1'b1;
      end
    end
  end

  // A landing read must find the output register free.
  a_pend_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !out_valid_r)
    else $error("dequeue data landing on an occupied result register");

  // No beat is taken while a read is in flight.
  a_no_fire_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !in_fire)
    else $error("request accepted during dequeue read");

  // A dequeue that found a word raises pend_r, then delivers it as ST_OK.
  a_deq_lands: assert property (@(posedge clk) disable iff (!rst_n)
    deq_go |=> (pend_r ##1 (out_valid_r && out_status_r == ST_OK)))
    else $error("dequeue result did not appear");

  // Fill counts never exceed the level depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !cnt_ovf)
    else $error("level fill count overflow");

  // FULL and EMPTY results carry zero payload.
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_value_r == '0 && out_level_r == '0))
    else $error("non-zero payload on a FULL or EMPTY result");

endmodule
